@@ design/assert_macros.svh @@
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define AMDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("amdf check failed");

// Next-cycle implication, held off while reset is low
`define AMDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("amdf check failed");

// Next-cycle implication that also holds through reset
`define AMDF_ASSERT_NXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("amdf check failed");

`endif

@@ design/amdf_pkg.sv @@
// Package: widths, register indexes, reset values, controller states and command/status types
package amdf_pkg;

    localparam int MAX_LAG_DEF     = 512;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MEDIAN_TAPS     = 3;
    localparam int FREQ_W          = 22;
    localparam int PERIOD_W        = 10;
    localparam int RATE_W          = 18;
    localparam int MINP_W          = 9;
    localparam int MAXP_W          = 10;
    localparam int CFG_W           = 18;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD  = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;
    localparam logic [MINP_W-1:0] MINP_RST = 9'd96;
    localparam logic [MAXP_W-1:0] MAXP_RST = 10'd240;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AMDF_RUN,
        S_AMDF_DRAIN,
        S_AMDF_CMP,
        S_SLIDE_RUN,
        S_SLIDE_DRAIN,
        S_MEDIAN,
        S_RMS_INIT,
        S_RMS_RUN,
        S_RMS_DRAIN,
        S_LOAD_SQ,
        S_DIV_SQ,
        S_SQRT_LOAD,
        S_SQRT,
        S_LOAD_FQ,
        S_DIV_FQ,
        S_EMIT,
        S_EMIT_BAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic amdf_issue;
        logic amdf_cmp;
        logic slide_issue;
        logic median;
        logic rms_init;
        logic rms_issue;
        logic div_load_sq;
        logic div_load_fq;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic emit;
        logic emit_bad;
    } t_cmd;

    typedef struct packed {
        logic cfg_bad;
        logic win_full;
        logic pos_last;
        logic lag_last;
        logic q_last;
        logic per_zero;
        logic cnt_last;
        logic div_last;
        logic sqrt_last;
        logic out_free;
    } t_status;

endpackage

@@ design/amdf_ctrl.sv @@
// Controller: sequences the lag search, slide, median, level and frequency steps
module amdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  amdf_pkg::t_status i_status,
    output logic              o_in_ready,
    output amdf_pkg::t_cmd    o_cmd
);
    import amdf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.cfg_bad) begin
                        n_state = S_EMIT_BAD;
                    end else if (i_status.win_full) begin
                        n_state = S_AMDF_RUN;
                    end else begin
                        n_state = S_RMS_INIT;
                    end
                end
            end
            S_AMDF_RUN: begin
                o_cmd.amdf_issue = 1'b1;
                if (i_status.pos_last) begin
                    n_state = S_AMDF_DRAIN;
                end
            end
            S_AMDF_DRAIN: begin
                n_state = S_AMDF_CMP;
            end
            S_AMDF_CMP: begin
                o_cmd.amdf_cmp = 1'b1;
                n_state = i_status.lag_last ? S_SLIDE_RUN : S_AMDF_RUN;
            end
            S_SLIDE_RUN: begin
                o_cmd.slide_issue = 1'b1;
                if (i_status.q_last) begin
                    n_state = S_SLIDE_DRAIN;
                end
            end
            S_SLIDE_DRAIN: begin
                n_state = S_MEDIAN;
            end
            S_MEDIAN: begin
                o_cmd.median = 1'b1;
                n_state = S_RMS_INIT;
            end
            S_RMS_INIT: begin
                o_cmd.rms_init = 1'b1;
                n_state = i_status.per_zero ? S_EMIT : S_RMS_RUN;
            end
            S_RMS_RUN: begin
                o_cmd.rms_issue = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_RMS_DRAIN;
                end
            end
            S_RMS_DRAIN: begin
                n_state = S_LOAD_SQ;
            end
            S_LOAD_SQ: begin
                o_cmd.div_load_sq = 1'b1;
                n_state = S_DIV_SQ;
            end
            S_DIV_SQ: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_SQRT_LOAD;
                end
            end
            S_SQRT_LOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = S_LOAD_FQ;
                end
            end
            S_LOAD_FQ: begin
                o_cmd.div_load_fq = 1'b1;
                n_state = S_DIV_FQ;
            end
            S_DIV_FQ: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the result until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/amdf_dp.sv @@
// Datapath: sample memory, lag sums, median, serial divider and square root
module amdf_dp #(
    parameter int MAX_LAG     = amdf_pkg::MAX_LAG_DEF,
    parameter int SAMPLE_BITS = amdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [amdf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [amdf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_out_ready,
    input  amdf_pkg::t_cmd                      i_cmd,
    output amdf_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    output logic [amdf_pkg::FREQ_W-1:0]         o_frequency,
    output logic [amdf_pkg::PERIOD_W-1:0]       o_period,
    output logic [SAMPLE_BITS-1:0]              o_rms_level,
    output logic                                o_analysis_done,
    output logic                                o_config_error
);
    import amdf_pkg::*;

    localparam int DEPTH  = 2 * MAX_LAG;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = POS_W + 1;
    localparam int LAG_W  = $clog2(MAX_LAG + 1);
    localparam int CW     = (LAG_W > MAXP_W) ? LAG_W : MAXP_W;
    localparam int SUM_W  = SAMPLE_BITS + 1 + POS_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LAG_W;
    localparam int DIV_W  = (SQ_W > FREQ_W) ? SQ_W : FREQ_W;
    localparam int RT_W   = DIV_W + (DIV_W % 2);
    localparam int IT_W   = $clog2(DIV_W + 1);
    localparam logic [CW-1:0] LAG_CAP = CW'(MAX_LAG);

    function automatic logic [CW-1:0] cap_lag(input logic [MAXP_W-1:0] m);
        logic [CW-1:0] e;
        e = CW'(m);
        return (e > LAG_CAP) ? LAG_CAP : e;
    endfunction

    function automatic logic [LAG_W-1:0] mid_period(input logic [MINP_W-1:0] lo,
                                                   input logic [MAXP_W-1:0] hi);
        logic [CW:0] s;
        s = {1'b0, CW'(lo)} + {1'b0, cap_lag(hi)};
        return LAG_W'(s >> 1);
    endfunction

    function automatic logic [LAG_W-1:0] mid3(input logic [LAG_W-1:0] a,
                                             input logic [LAG_W-1:0] b,
                                             input logic [LAG_W-1:0] c);
        logic [LAG_W-1:0] lo, hi, t;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        t  = (hi < c) ? hi : c;
        return (lo > t) ? lo : t;
    endfunction

    // configuration
    logic [RATE_W-1:0] r_rate;
    logic [MINP_W-1:0] r_min;
    logic [MAXP_W-1:0] r_max;

    // tracker state
    logic [POS_W-1:0] r_wp;
    logic             r_filled;
    logic [LAG_W-1:0] r_cur;
    logic [LAG_W-1:0] r_hist [MEDIAN_TAPS];
    logic [LAG_W-1:0] r_med  [MEDIAN_TAPS];
    logic [1:0]       r_ptr;
    logic             r_done;

    // working registers
    logic [POS_W-1:0] r_pos;
    logic [LAG_W-1:0] r_lag;
    logic [SUM_W-1:0] r_tot, r_least;
    logic [LAG_W-1:0] r_best;
    logic [LAG_W-1:0] r_q;
    logic [EXT_W-1:0] r_ra;
    logic [LAG_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_sq;
    logic [DIV_W-1:0] r_dq;
    logic [LAG_W-1:0] r_rem;
    logic [IT_W-1:0]  r_it;
    logic [RT_W-1:0]  r_v, r_r, r_bit;
    logic [SAMPLE_BITS-1:0] r_rms;
    logic             r_rd_v, r_tb_v, r_cp_v, r_sq_v, r_ta_v;
    logic [ADDR_W-1:0] r_cp_a;

    // output register
    logic                   r_ovalid;
    logic [FREQ_W-1:0]      r_ofreq;
    logic [PERIOD_W-1:0]    r_oper;
    logic [SAMPLE_BITS-1:0] r_orms;
    logic                   r_odone, r_oerr;

    // sample memory
    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_da, r_db;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa, mem_ra, mem_rb;
    logic [SAMPLE_BITS-1:0] mem_wd;

    logic [CW-1:0]    eff;
    logic [POS_W-1:0] win;
    logic             cfg_bad;
    logic [EXT_W-1:0] pb, start_raw, start_pos;
    logic             tb_flag, ta_flag;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          absd;
    logic signed [SAMPLE_BITS-1:0] va;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic [LAG_W:0]   div_t;
    logic             div_ge;
    logic [RT_W:0]    rb_sum;
    logic             rt_ge;
    logic [LAG_W-1:0] h_new [MEDIAN_TAPS];
    logic [LAG_W-1:0] med_val;
    logic [1:0]       prev_idx;
    logic [MINP_W-1:0] n_min;
    logic [MAXP_W-1:0] n_max;

    assign eff     = cap_lag(r_max);
    assign win     = POS_W'({eff, 1'b0});
    assign cfg_bad = (eff <= CW'(r_min));

    assign pb      = EXT_W'(r_pos) + EXT_W'(r_lag);
    assign tb_flag = (pb < EXT_W'(win));
    assign ta_flag = (r_ra < EXT_W'(win)) && (r_filled || (r_ra < EXT_W'(r_wp)));

    assign start_raw = EXT_W'(r_wp) + EXT_W'(win) - EXT_W'(r_cur);
    assign start_pos = (start_raw >= EXT_W'(win)) ? start_raw - EXT_W'(win) : start_raw;

    assign mem_we = (i_cmd.accept && !cfg_bad) || r_cp_v;
    assign mem_wa = r_cp_v ? r_cp_a : ADDR_W'(r_wp);
    assign mem_wd = r_cp_v ? r_db : i_sample;
    assign mem_ra = i_cmd.rms_issue ? ADDR_W'(r_ra) : ADDR_W'(r_pos);
    assign mem_rb = i_cmd.amdf_issue ? ADDR_W'(pb) : ADDR_W'(r_q) + ADDR_W'(eff);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_da <= r_mem[mem_ra];
        r_db <= r_mem[mem_rb];
    end

    // taps past the window read zero
    assign diff = $signed({(r_tb_v ? r_db[SAMPLE_BITS-1] : 1'b0), (r_tb_v ? r_db : '0)})
                - $signed({r_da[SAMPLE_BITS-1], r_da});
    assign absd = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign va   = r_ta_v ? $signed(r_da) : '0;
    assign prod = va * va;

    assign div_t  = {r_rem, r_dq[DIV_W-1]};
    assign div_ge = (div_t >= {1'b0, r_cur});
    assign rb_sum = {1'b0, r_r} + {1'b0, r_bit};
    assign rt_ge  = ({1'b0, r_v} >= rb_sum);

    always_comb begin
        for (int k = 0; k < MEDIAN_TAPS; k++) begin
            h_new[k] = r_hist[k];
        end
        h_new[r_ptr] = r_best;
        med_val = mid3(h_new[0], h_new[1], h_new[2]);
        case (r_ptr)
            2'd0:    prev_idx = 2'd2;
            2'd1:    prev_idx = 2'd0;
            default: prev_idx = 2'd1;
        endcase
        n_min = (i_cfg_index == REG_MIN_PERIOD) ? i_cfg_data[MINP_W-1:0] : r_min;
        n_max = (i_cfg_index == REG_MAX_PERIOD) ? i_cfg_data[MAXP_W-1:0] : r_max;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_min    <= MINP_RST;
            r_max    <= MAXP_RST;
            r_wp     <= '0;
            r_filled <= 1'b0;
            r_cur    <= mid_period(MINP_RST, MAXP_RST);
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
            r_rd_v   <= 1'b0;
            r_cp_v   <= 1'b0;
            r_sq_v   <= 1'b0;
            for (int k = 0; k < MEDIAN_TAPS; k++) begin
                r_hist[k] <= '0;
                r_med[k]  <= '0;
            end
        end else begin
            r_rd_v <= i_cmd.amdf_issue;
            r_cp_v <= i_cmd.slide_issue;
            r_sq_v <= i_cmd.rms_issue;
            if (i_cmd.accept && !cfg_bad) begin
                r_wp <= r_wp + POS_W'(1);
            end
            if (i_cmd.median) begin
                for (int k = 0; k < MEDIAN_TAPS; k++) begin
                    r_hist[k] <= h_new[k];
                end
                r_med[r_ptr] <= med_val;
                r_cur        <= r_med[prev_idx];
                r_ptr        <= (r_ptr == 2'd2) ? 2'd0 : r_ptr + 2'd1;
                r_wp         <= POS_W'(eff);
                r_filled     <= 1'b1;
            end
            if (i_cmd.emit || i_cmd.emit_bad) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SAMPLE_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                    REG_MIN_PERIOD, REG_MAX_PERIOD: begin
                        // period change: restart the tracker
                        r_min    <= n_min;
                        r_max    <= n_max;
                        r_wp     <= '0;
                        r_filled <= 1'b0;
                        r_ptr    <= '0;
                        r_cur    <= mid_period(n_min, n_max);
                        for (int k = 0; k < MEDIAN_TAPS; k++) begin
                            r_hist[k] <= '0;
                            r_med[k]  <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers and payload
    always_ff @(posedge i_clk) begin
        r_tb_v <= tb_flag;
        r_ta_v <= ta_flag;
        r_cp_a <= ADDR_W'(r_q);
        if (i_cmd.accept) begin
            r_pos  <= '0;
            r_lag  <= LAG_W'(r_min);
            r_tot  <= '0;
            r_q    <= '0;
            r_done <= 1'b0;
        end
        if (i_cmd.amdf_issue) begin
            r_pos <= r_pos + POS_W'(1);
        end
        if (r_rd_v) begin
            r_tot <= r_tot + SUM_W'(absd);
        end
        if (i_cmd.amdf_cmp) begin
            // first minimum wins: replace only on a strictly smaller sum
            if ((r_lag == LAG_W'(r_min)) || (r_tot < r_least)) begin
                r_least <= r_tot;
                r_best  <= r_lag;
            end
            r_tot <= '0;
            r_pos <= '0;
            r_lag <= r_lag + LAG_W'(1);
        end
        if (i_cmd.slide_issue) begin
            r_q <= r_q + LAG_W'(1);
        end
        if (i_cmd.median) begin
            r_done <= 1'b1;
        end
        if (i_cmd.rms_init) begin
            r_ra  <= start_pos;
            r_cnt <= '0;
            r_sq  <= '0;
        end
        if (i_cmd.rms_issue) begin
            r_ra  <= r_ra + EXT_W'(1);
            r_cnt <= r_cnt + LAG_W'(1);
        end
        if (r_sq_v) begin
            r_sq <= r_sq + SQ_W'($unsigned(prod));
        end
        if (i_cmd.div_load_sq || i_cmd.div_load_fq) begin
            r_dq  <= i_cmd.div_load_sq ? DIV_W'(r_sq) : DIV_W'(FREQ_W'({r_rate, 4'd0}));
            r_rem <= '0;
            r_it  <= '0;
        end
        if (i_cmd.div_load_fq) begin
            r_rms <= SAMPLE_BITS'(r_r);
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? LAG_W'(div_t - {1'b0, r_cur}) : LAG_W'(div_t);
            r_dq  <= {r_dq[DIV_W-2:0], div_ge};
            r_it  <= r_it + IT_W'(1);
        end
        if (i_cmd.sqrt_load) begin
            r_v   <= RT_W'(r_dq);
            r_r   <= '0;
            r_bit <= RT_W'(1) << (RT_W - 2);
            r_it  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (rt_ge) begin
                r_v <= r_v - RT_W'(rb_sum);
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_it  <= r_it + IT_W'(1);
        end
        if (i_cmd.emit) begin
            r_ofreq <= (r_cur == '0) ? '0 : FREQ_W'(r_dq);
            r_oper  <= PERIOD_W'(r_cur);
            r_orms  <= (r_cur == '0) ? '0 : r_rms;
            r_odone <= r_done;
            r_oerr  <= 1'b0;
        end else if (i_cmd.emit_bad) begin
            r_ofreq <= '0;
            r_oper  <= '0;
            r_orms  <= '0;
            r_odone <= 1'b0;
            r_oerr  <= 1'b1;
        end
    end

    always_comb begin
        o_status.cfg_bad   = cfg_bad;
        o_status.win_full  = (EXT_W'(r_wp) + EXT_W'(1)) >= EXT_W'(win);
        o_status.pos_last  = (r_pos == win - POS_W'(1));
        o_status.lag_last  = (CW'(r_lag) == eff);
        o_status.q_last    = (CW'(r_q) == eff - CW'(1));
        o_status.per_zero  = (r_cur == '0);
        o_status.cnt_last  = (r_cnt == r_cur - LAG_W'(1));
        o_status.div_last  = (r_it == IT_W'(DIV_W - 1));
        o_status.sqrt_last = (r_it == IT_W'(RT_W / 2 - 1));
        o_status.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid     = r_ovalid;
    assign o_frequency     = r_ofreq;
    assign o_period        = r_oper;
    assign o_rms_level     = r_orms;
    assign o_analysis_done = r_odone;
    assign o_config_error  = r_oerr;

endmodule

@@ design/amdf_pitch_tracker.sv @@
// Top level: AMDF pitch tracker with valid/ready sample and result channels
// One sample is taken at a time. The level sum reads one stored sample a cycle, and
// the serial divider (used for the mean square and the frequency) and the square root
// retire one bit or one root digit a cycle. The divider is the wider of FREQ_W and
// 2*SAMPLE_BITS + clog2(MAX_LAG+1) bits, 42 by default. A sample that fills the window
// also runs the lag search, which takes one difference term a cycle from the two read
// ports of the sample memory, and the slide, which copies one sample a cycle. No clearing
// pass follows reset or a period write: a fill mark makes unwritten entries read zero.
// The next sample is taken while a finished result still waits at the output register.
module amdf_pitch_tracker #(
    parameter int MAX_LAG     = amdf_pkg::MAX_LAG_DEF,
    parameter int SAMPLE_BITS = amdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [amdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amdf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [amdf_pkg::FREQ_W-1:0]    o_frequency,
    output logic [amdf_pkg::PERIOD_W-1:0]  o_period,
    output logic [SAMPLE_BITS-1:0]         o_rms_level,
    output logic                           o_analysis_done,
    output logic                           o_config_error
);
    import amdf_pkg::*;

    t_cmd    cmd;
    t_status status;

    amdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    amdf_dp #(
        .MAX_LAG     (MAX_LAG),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_frequency     (o_frequency),
        .o_period        (o_period),
        .o_rms_level     (o_rms_level),
        .o_analysis_done (o_analysis_done),
        .o_config_error  (o_config_error)
    );

endmodule

@@ design/amdf_chk.sv @@
// Port checker for the pitch tracker, bound to the top level
`include "assert_macros.svh"

module amdf_chk #(
    parameter int SAMPLE_BITS = amdf_pkg::SAMPLE_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [amdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [amdf_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic signed [SAMPLE_BITS-1:0]  i_sample,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [amdf_pkg::FREQ_W-1:0]    o_frequency,
    input logic [amdf_pkg::PERIOD_W-1:0]  o_period,
    input logic [SAMPLE_BITS-1:0]         o_rms_level,
    input logic                           o_analysis_done,
    input logic                           o_config_error
);

    // a rejected sample reports nothing but the error flag
    `AMDF_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_config_error,
        (o_frequency == '0) && (o_period == '0) && (o_rms_level == '0) && !o_analysis_done)

    // one item at a time: busy right after an item is taken
    `AMDF_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result holds
    `AMDF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_frequency) && $stable(o_period) &&
        $stable(o_rms_level) && $stable(o_analysis_done) && $stable(o_config_error))

    // reset drops the output channel
    `AMDF_ASSERT_NXT_RST(a_rst_clear, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind amdf_pitch_tracker amdf_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_amdf_chk (.*);

@@ tb/sv/amdf_track_checker.sv @@
// Checker for the pitch tracker: predicts each result and compares it with the block's output
module amdf_track_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [amdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amdf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic signed [15:0]             i_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [amdf_pkg::FREQ_W-1:0]    i_frequency,
    input  logic [amdf_pkg::PERIOD_W-1:0]  i_period,
    input  logic [15:0]                    i_rms_level,
    input  logic                           i_analysis_done,
    input  logic                           i_config_error,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [21:0] frequency;
        logic [9:0]  period;
        logic [15:0] rms_level;
        logic        analysis_done;
        logic        config_error;
    } t_pitch_result;

    t_pitch_result expected_results[$];

    int          window_store[1024];
    int unsigned fill_pos;
    int unsigned tracked_period;
    int unsigned lag_history[3];
    int unsigned median_history[3];
    int unsigned median_ptr;
    int unsigned rate_hz;
    int unsigned shortest_lag;
    int unsigned longest_lag;

    function automatic int unsigned capped_longest();
        return (longest_lag > 512) ? 512 : longest_lag;
    endfunction

    function automatic void restart_tracker();
        foreach (window_store[k]) window_store[k] = 0;
        for (int k = 0; k < 3; k++) begin
            lag_history[k] = 0;
            median_history[k] = 0;
        end
        fill_pos = 0;
        median_ptr = 0;
        tracked_period = (shortest_lag + capped_longest()) / 2;
    endfunction

    function automatic longint window_tap(int unsigned p, int unsigned win);
        return (p < win && p < 1024) ? longint'(window_store[p]) : 0;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned median_of_three(int unsigned a, int unsigned b,
                                                    int unsigned c);
        int unsigned lo;
        int unsigned hi;
        int unsigned t;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        t  = (hi < c) ? hi : c;
        return (lo > t) ? lo : t;
    endfunction

    function automatic int unsigned least_difference_lag(int unsigned win);
        int unsigned winner;
        longint unsigned least;
        longint unsigned tot;
        longint d;
        winner = shortest_lag;
        least = 0;
        for (int unsigned lag = shortest_lag; lag <= capped_longest(); lag++) begin
            tot = 0;
            for (int unsigned p = 0; p < win; p++) begin
                d = window_tap(p + lag, win) - window_tap(p, win);
                tot += (d < 0) ? -d : d;
            end
            // first minimum wins on a tie
            if (lag == shortest_lag || tot < least) begin
                least = tot;
                winner = lag;
            end
        end
        return winner;
    endfunction

    function automatic t_pitch_result track_sample(logic signed [15:0] s);
        t_pitch_result r;
        int unsigned win;
        int unsigned maxp;
        int unsigned lag;
        int unsigned start;
        longint unsigned sq;
        longint v;
        r = '0;
        if (capped_longest() <= shortest_lag) begin
            r.config_error = 1'b1;
            return r;
        end
        maxp = capped_longest();
        win = 2 * maxp;
        if (fill_pos < win) window_store[fill_pos] = int'(s);
        fill_pos++;
        if (fill_pos >= win) begin
            lag = least_difference_lag(win);
            for (int unsigned q = 0; q < maxp; q++) window_store[q] = window_store[q + maxp];
            fill_pos = maxp;
            lag_history[median_ptr] = lag;
            median_history[median_ptr] =
                median_of_three(lag_history[0], lag_history[1], lag_history[2]);
            tracked_period = median_history[(median_ptr + 2) % 3];
            median_ptr = (median_ptr + 1) % 3;
            r.analysis_done = 1'b1;
        end
        r.period = tracked_period[9:0];
        if (tracked_period != 0) begin
            start = (fill_pos + win - tracked_period) % win;
            sq = 0;
            for (int unsigned t = 0; t < tracked_period; t++) begin
                v = window_tap(start + t, win);
                sq += v * v;
            end
            r.rms_level = 16'(floor_root(sq / tracked_period));
            r.frequency = 22'((longint'(rate_hz) * 16) / tracked_period);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pitch_result got;
        t_pitch_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            rate_hz = amdf_pkg::RATE_RST;
            shortest_lag = amdf_pkg::MINP_RST;
            longest_lag = amdf_pkg::MAXP_RST;
            restart_tracker();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    amdf_pkg::REG_SAMPLE_RATE: rate_hz = i_cfg_data[17:0];
                    amdf_pkg::REG_MIN_PERIOD: begin
                        shortest_lag = i_cfg_data[8:0];
                        restart_tracker();
                    end
                    amdf_pkg::REG_MAX_PERIOD: begin
                        longest_lag = i_cfg_data[9:0];
                        restart_tracker();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(track_sample(i_sample));
            if (i_out_valid && i_out_ready) begin
                got = '{i_frequency, i_period, i_rms_level, i_analysis_done, i_config_error};
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

@@ tb/sv/tb_amdf_pitch_tracker.sv @@
// Testbench top: drives samples and configuration into the pitch tracker and gives the verdict
module tb_amdf_pitch_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 100000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [amdf_pkg::CFG_IDX_W-1:0] cfg_index = amdf_pkg::REG_SAMPLE_RATE;
    logic [amdf_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [15:0]             sample = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [amdf_pkg::FREQ_W-1:0]    frequency;
    logic [amdf_pkg::PERIOD_W-1:0]  period;
    logic [15:0]                    rms_level;
    logic                           analysis_done;
    logic                           config_error;
    int                             fail_count;
    int                             pending;
    int                             burst_left = 0;
    int                             samples_sent = 0;
    int                             results_seen = 0;
    int                             idle_cycles = 0;
    int                             hold_left = 0;
    bit                             hold_done = 1'b0;
    int                             stall_pct = 0;

    always #5 i_clk = ~i_clk;

    amdf_pitch_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_sample(sample),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_frequency(frequency), .o_period(period), .o_rms_level(rms_level),
        .o_analysis_done(analysis_done), .o_config_error(config_error)
    );

    amdf_track_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_sample(sample),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_frequency(frequency), .i_period(period), .i_rms_level(rms_level),
        .i_analysis_done(analysis_done), .i_config_error(config_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: stall pattern of its own, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) results_seen <= results_seen + 1;
            if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 2) * 35;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 60 && in_valid) begin
                hold_done <= 1'b1;
                hold_left <= 2000;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog on cycles with no item accepted on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic put_sample(input logic signed [15:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        sample <= s;
        do @(posedge i_clk); while (!in_ready);
        burst_left--;
        samples_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_tracker(input int unsigned rate, input int unsigned minp,
                               input int unsigned maxp);
        cfg_we <= 1'b1;
        cfg_index <= amdf_pkg::REG_SAMPLE_RATE;
        cfg_data <= 18'(rate);
        @(posedge i_clk);
        cfg_index <= amdf_pkg::REG_MIN_PERIOD;
        cfg_data <= 18'(minp);
        @(posedge i_clk);
        cfg_index <= amdf_pkg::REG_MAX_PERIOD;
        cfg_data <= 18'(maxp);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    initial begin
        int unsigned minp;
        int unsigned maxp;
        int unsigned rate;
        int unsigned tone;
        int amp;
        int count;
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: field extremes
        put_sample(16'sh7FFF);
        put_sample(-16'sh8000);
        put_sample(16'sh0000);
        put_sample(-16'sh0001);
        put_sample(16'sh0001);
        put_sample(16'sh5555);
        put_sample(16'shAAAA);
        settle();
        // max not above min: samples dropped with an error flag, zero sample rate
        set_tracker(0, 10, 10);
        put_sample(16'sh1234);
        put_sample(-16'sh4321);
        settle();
        set_tracker(0, 0, 0);
        put_sample(16'sh7FFF);
        settle();
        // longest lag beyond 512 is capped to 512, half the store size
        set_tracker(262143, 511, 1023);
        put_sample(-16'sh8000);
        put_sample(16'sh7FFF);
        put_sample(16'sh0100);
        settle();
        // zero shortest lag: lag zero wins and the period falls to zero
        set_tracker(192000, 0, 3);
        for (int k = 0; k < 12; k++) put_sample(k[0] ? 16'sh7000 : -16'sh7000);
        settle();

        while (samples_sent < 265) begin
            case ($urandom_range(0, 3))
                0: rate = 1000;
                1: rate = 48000;
                2: rate = 192000;
                default: rate = $urandom_range(0, 262143);
            endcase
            minp = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
            maxp = minp + $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0) maxp = minp - ((minp > 0) ? $urandom_range(0, 1) : 0);
            set_tracker(rate, minp, maxp);
            count = $urandom_range(20, 50);
            mode = $urandom_range(0, 3);
            tone = $urandom_range((minp > 2) ? minp : 2, (maxp > 2) ? maxp : 2);
            amp = $urandom_range(100, 32767);
            for (int k = 0; k < count; k++) begin
                if (mode == 0)
                    put_sample(16'($urandom()));
                else if (mode == 1)
                    put_sample(clip16(((k % tone) < tone / 2 ? amp : -amp)
                                      + $urandom_range(0, 400) - 200));
                else
                    put_sample(clip16(((k % tone) * 2 * amp) / tone - amp
                                      + $urandom_range(0, 64) - 32));
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
